// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

  localparam int DIGITS_DEF = 8;
  localparam int VALUE_W    = 27;
  localparam int SEL_W      = 3;
  localparam int SEG_W      = 8;
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_SCAN = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take a new number into the converter
    logic shift;  // one double-dabble step
    logic write;  // write the converted patterns into the display store
    logic scan;   // drive the current position and advance it
  } ssd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_last;  // the current shift is the last one
    logic out_busy;   // a result waits and the receiver stalls
  } ssd_sts_t;

  // Common-cathode pattern of one decimal digit.
  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/ssd_ctrl.sv =====
module ssd_ctrl import ssd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_stall,
  input  ssd_sts_t sts,
  output ssd_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CONV  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE) || sts.out_busy;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_LOAD) begin
            cmd.load  = 1'b1;
            state_nxt = ST_CONV;
          end else begin
            cmd.scan = 1'b1;
          end
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (sts.conv_last) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/ssd_dp.sv =====
module ssd_dp import ssd_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [VALUE_W-1:0] in_value,
  input  ssd_cmd_t           cmd,
  output ssd_sts_t           sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SEL_W-1:0]   out_digit_select,
  output logic [SEG_W-1:0]   out_segments
);

  localparam int BCD_W = 4 * DIGITS;

  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r, bcd_adj;
  logic               ovf_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SEG_W-1:0]   store_r [DIGITS];
  logic [SEG_W-1:0]   pat     [DIGITS];
  logic [SEG_W-1:0]   rd_seg;
  logic [SEL_W-1:0]   pos_r;
  logic               out_valid_r;
  logic [SEL_W-1:0]   sel_r;
  logic [SEG_W-1:0]   seg_r;

  assign sts.conv_last = (cnt_r == CNT_W'(VALUE_W - 1));
  assign sts.out_busy  = out_valid_r && out_stall;

  // Add-3 correction on every decimal digit before the shift.
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
  end

  // Digit k counts from the right. A position is blank when it is not the
  // rightmost one and neither it nor any more significant digit is nonzero.
  // The overflow flag stands for digits beyond the display.
  always_comb begin
    logic acc;
    acc = ovf_r;
    for (int k = DIGITS - 1; k >= 0; k--) begin
      acc = acc || (bcd_r[4*k +: 4] != 4'd0);
      if (k != 0 && !acc) begin
        pat[DIGITS-1-k] = '0;
      end else begin
        pat[DIGITS-1-k] = seg_code(bcd_r[4*k +: 4]);
      end
    end
  end

  always_comb begin
    rd_seg = '0;
    for (int p = 0; p < DIGITS; p++) begin
      if (pos_r == SEL_W'(p)) begin
        rd_seg = store_r[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= in_value;
      bcd_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.shift) begin
      bin_r <= {bin_r[VALUE_W-2:0], 1'b0};
      bcd_r <= {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
      ovf_r <= ovf_r || bcd_adj[BCD_W-1];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < DIGITS; p++) begin
        store_r[p] <= '0;
      end
    end else if (cmd.write) begin
      for (int p = 0; p < DIGITS; p++) begin
        store_r[p] <= pat[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan) begin
        out_valid_r <= 1'b1;
        if (pos_r == SEL_W'(DIGITS - 1)) begin
          pos_r <= '0;
        end else begin
          pos_r <= pos_r + SEL_W'(1);
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      sel_r <= pos_r;
      seg_r <= rd_seg;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_digit_select = sel_r;
  assign out_segments     = seg_r;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= SEL_W'(DIGITS - 1))
    else $error("scan position beyond the last digit");

  a_write_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |-> $past(cmd.shift && sts.conv_last))
    else $error("store written without a finished conversion");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !(out_valid_r && out_stall))
    else $error("scan request overwrites a stalled result");

  a_scan_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |=> out_valid_r)
    else $error("scan request gave no result");
`endif

endmodule

// ===== hdl/seven_segment_scan_display.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_kind, in_value
// out_     output     out_valid/out_stall out_digit_select, out_segments
//
// A scan request's result appears in the output register the cycle after it
// is accepted. A load request is accepted, then runs one double-dabble shift
// per bit of in_value, then one store write. in_stall is high while a
// conversion or its store write runs and while a result waits under
// out_stall. Reset (synchronous, active low) blanks the display store and
// sets the scan position to the leftmost digit.
module seven_segment_scan_display import ssd_pkg::*; #(
  parameter int DIGITS = DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SEL_W-1:0]   out_digit_select,
  output logic [SEG_W-1:0]   out_segments
);

  ssd_cmd_t cmd;
  ssd_sts_t sts;

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssd_dp #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_digit_select (out_digit_select),
    .out_segments     (out_segments)
  );

endmodule
